>>> rtl/gillespie_jump_select_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the jump select block
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GILLESPIE_JUMP_SELECT_MACROS_SVH
`define GILLESPIE_JUMP_SELECT_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define GJS_ASSERT_NOW(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |-> (effect)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define GJS_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error(msg);

`endif

>>> rtl/gjs_pkg.sv
// ----------------------------------------------------------------------------
// gjs_pkg
// Shared constants and result codes of the jump select block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gjs_pkg;

  // Default depth of the option list
  localparam int unsigned MAX_OPTIONS_DEF = 256;

  // ln(2) as an unsigned Q0.32 fraction
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  // Result codes, also used as job kinds in the queue
  localparam logic [1:0] ST_STEP   = 2'd0;
  localparam logic [1:0] ST_ABSORB = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

endpackage

>>> rtl/gjs_front.sv
// ----------------------------------------------------------------------------
// gjs_front
// Accepts option beats, stores prefix sums and targets, classifies the
// final beat of each state and pushes one job into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gjs_front #(
  parameter int unsigned MAX_OPTIONS = gjs_pkg::MAX_OPTIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [31:0]                  current_state_i,
  input  logic signed [31:0]                  target_state_i,
  input  logic [31:0]                         rate_i,
  input  logic [31:0]                         uniform_time_i,
  input  logic [31:0]                         uniform_pick_i,
  input  logic                                last_i,
  input  logic                                no_options_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output logic [2+32+$clog2(MAX_OPTIONS+1)+32+$clog2(MAX_OPTIONS)+64-1:0] job_data_o,
  input  logic                                rd_en_i,
  input  logic [$clog2(MAX_OPTIONS)-1:0]      rd_addr_i,
  output logic [32+$clog2(MAX_OPTIONS)-1:0]   rd_sum_o,
  output logic [31:0]                         rd_tgt_o,
  input  logic                                scan_done_i,
  output logic                                mem_busy_o
);
  import gjs_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_OPTIONS);
  localparam int unsigned CNT_W  = $clog2(MAX_OPTIONS + 1);
  localparam int unsigned SUM_W  = 32 + ADDR_W;

  logic [SUM_W-1:0] sums_mem [MAX_OPTIONS];
  logic [31:0]      tgts_mem [MAX_OPTIONS];

  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] total_q;
  logic             ovf_q;
  logic             busy_q;
  logic [SUM_W-1:0] rd_sum_q;
  logic [31:0]      rd_tgt_q;

  logic             accept;
  logic             ends;
  logic             wr;
  logic [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0] tot_fin;
  logic [CNT_W-1:0] cnt_fin;
  logic             ovf_fin;
  logic [1:0]       kind;

  // Take beats only while the memory is ours and the queue has room
  assign in_ready_o = !busy_q && job_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ends       = no_options_i || last_i;

  // Classify the beat
  always_comb begin
    wr      = !no_options_i && (cnt_q < CNT_W'(MAX_OPTIONS));
    sum_new = total_q + SUM_W'(rate_i);
    tot_fin = wr ? sum_new : total_q;
    cnt_fin = wr ? cnt_q + CNT_W'(1) : cnt_q;
    ovf_fin = ovf_q || !wr;
    if (no_options_i) begin
      kind = ST_ABSORB;
    end else if (ovf_fin || (tot_fin == '0)) begin
      kind = ST_ERROR;
    end else begin
      kind = ST_STEP;
    end
  end

  // Push a job on the final beat of a state
  assign job_valid_o = accept && ends;
  assign job_data_o  = {kind, current_state_i, cnt_fin, tot_fin, uniform_time_i,
                        uniform_pick_i};

  // Track the list and hold the memory while a step job scans it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      if (accept) begin
        if (ends) begin
          cnt_q   <= '0;
          total_q <= '0;
          ovf_q   <= 1'b0;
        end else begin
          cnt_q   <= cnt_fin;
          total_q <= tot_fin;
          ovf_q   <= ovf_fin;
        end
      end
      if (job_valid_o && (kind == ST_STEP)) begin
        busy_q <= 1'b1;
      end else if (scan_done_i) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Option memory: write on load, registered read for the scan
  always_ff @(posedge clk_i) begin
    if (accept && wr) begin
      sums_mem[cnt_q[ADDR_W-1:0]] <= sum_new;
      tgts_mem[cnt_q[ADDR_W-1:0]] <= target_state_i;
    end
    if (rd_en_i) begin
      rd_sum_q <= sums_mem[rd_addr_i];
      rd_tgt_q <= tgts_mem[rd_addr_i];
    end
  end

  assign rd_sum_o   = rd_sum_q;
  assign rd_tgt_o   = rd_tgt_q;
  assign mem_busy_o = busy_q;

endmodule

>>> rtl/gjs_job_fifo.sv
// ----------------------------------------------------------------------------
// gjs_job_fifo
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gjs_job_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);
  logic [DATA_W-1:0] slot_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              push;
  logic              pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Store the pushed job
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

>>> rtl/gjs_back.sv
// ----------------------------------------------------------------------------
// gjs_back
// Carries out one job: -ln(u1) by normalise and repeated squaring, the
// divide by the total, the pick threshold and the prefix-sum scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gjs_back #(
  parameter int unsigned MAX_OPTIONS = gjs_pkg::MAX_OPTIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                job_valid_i,
  output logic                                job_ready_o,
  input  logic [2+32+$clog2(MAX_OPTIONS+1)+32+$clog2(MAX_OPTIONS)+64-1:0] job_data_i,
  output logic                                rd_en_o,
  output logic [$clog2(MAX_OPTIONS)-1:0]      rd_addr_o,
  input  logic [32+$clog2(MAX_OPTIONS)-1:0]   rd_sum_i,
  input  logic [31:0]                         rd_tgt_i,
  output logic                                scan_done_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic signed [31:0]                  next_state_o,
  output logic [31:0]                         sojourn_time_o
);
  import gjs_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_OPTIONS);
  localparam int unsigned CNT_W  = $clog2(MAX_OPTIONS + 1);
  localparam int unsigned SUM_W  = 32 + ADDR_W;
  localparam int unsigned OFS_TOT  = 64;
  localparam int unsigned OFS_CNT  = OFS_TOT + SUM_W;
  localparam int unsigned OFS_CUR  = OFS_CNT + CNT_W;
  localparam int unsigned OFS_KIND = OFS_CUR + 32;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NORM   = 4'd1;
  localparam logic [3:0] S_SQR    = 4'd2;
  localparam logic [3:0] S_LNLO   = 4'd3;
  localparam logic [3:0] S_LNSUM  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_THR    = 4'd6;
  localparam logic [3:0] S_THRSUM = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;

  // 32.0 in the Q6.32 log format
  localparam logic [37:0] LOG_TOP = {6'd32, 32'd0};

  logic [3:0]       state_q;
  logic [32:0]      m_q;
  logic [5:0]       e_q;
  logic [31:0]      mant_q;
  logic [31:0]      frac_q;
  logic [4:0]       iter_q;
  logic [63:0]      lo_prod_q;
  logic [5:0]       hi_q;
  logic [37:0]      dvd_q;
  logic [SUM_W-1:0] rem_q;
  logic [5:0]       dcnt_q;
  logic [63:0]      thr_lo_q;
  logic [SUM_W-1:0] thr_q;
  logic [SUM_W-1:0] total_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      up_q;
  logic [ADDR_W-1:0] addr_q;
  logic             issued_q;
  logic             pend_q;
  logic             pend_last_q;
  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [31:0]      next_q;
  logic [31:0]      time_q;

  logic [1:0]       job_kind;
  logic [63:0]      sq_prod;
  logic [32:0]      sq;
  logic [37:0]      nl;
  logic [37:0]      ln_sum;
  logic [SUM_W:0]   ren;
  logic             ge;
  logic [SUM_W-1:0] thr_sum;
  logic [ADDR_W-1:0] last_addr;
  logic             hit;
  logic             finish;
  logic             pop;

  assign job_kind  = job_data_i[OFS_KIND +: 2];
  assign job_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign pop       = job_valid_i && job_ready_o;

  // Datapath helpers
  always_comb begin
    sq_prod   = mant_q * mant_q;
    sq        = sq_prod[63:31];
    nl        = LOG_TOP - {e_q, frac_q};
    ln_sum    = 38'(hi_q * LN2_Q32) + 38'(lo_prod_q[63:32]);
    ren       = {rem_q, dvd_q[37]};
    ge        = (ren >= {1'b0, total_q});
    thr_sum   = SUM_W'(up_q * total_q[SUM_W-1:32]) + SUM_W'(thr_lo_q[63:32]);
    last_addr = ADDR_W'(cnt_q - CNT_W'(1));
    hit       = (rd_sum_i > thr_q);
    finish    = (state_q == S_SCAN) && pend_q && (hit || pend_last_q);
  end

  assign rd_en_o     = (state_q == S_SCAN) && !issued_q;
  assign rd_addr_o   = addr_q;
  assign scan_done_o = finish;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      m_q         <= '0;
      e_q         <= '0;
      mant_q      <= '0;
      frac_q      <= '0;
      iter_q      <= '0;
      lo_prod_q   <= '0;
      hi_q        <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      thr_lo_q    <= '0;
      thr_q       <= '0;
      total_q     <= '0;
      cnt_q       <= '0;
      up_q        <= '0;
      addr_q      <= '0;
      issued_q    <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= ST_STEP;
      next_q      <= '0;
      time_q      <= '0;
    end else begin
      // Drop the result once taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            total_q <= job_data_i[OFS_TOT +: SUM_W];
            cnt_q   <= job_data_i[OFS_CNT +: CNT_W];
            up_q    <= job_data_i[0 +: 32];
            m_q     <= {1'b0, job_data_i[32 +: 32]} + 33'd1;
            e_q     <= 6'd32;
            case (job_kind)
              ST_STEP: begin
                state_q <= S_NORM;
              end
              ST_ABSORB: begin
                out_valid_q <= 1'b1;
                status_q    <= ST_ABSORB;
                next_q      <= job_data_i[OFS_CUR +: 32];
                time_q      <= '0;
              end
              default: begin
                out_valid_q <= 1'b1;
                status_q    <= ST_ERROR;
                next_q      <= '1;
                time_q      <= '0;
              end
            endcase
          end
        end
        // Shift u+1 up to bit 32, counting the exponent down
        S_NORM: begin
          if (m_q[32]) begin
            mant_q  <= m_q[32:1];
            frac_q  <= '0;
            iter_q  <= '0;
            state_q <= S_SQR;
          end else begin
            m_q <= {m_q[31:0], 1'b0};
            e_q <= e_q - 6'd1;
          end
        end
        // One fraction bit of log2 per square
        S_SQR: begin
          if (sq[32]) begin
            mant_q <= sq[32:1];
            frac_q <= {frac_q[30:0], 1'b1};
          end else begin
            mant_q <= sq[31:0];
            frac_q <= {frac_q[30:0], 1'b0};
          end
          iter_q <= iter_q + 5'd1;
          if (iter_q == 5'd31) begin
            state_q <= S_LNLO;
          end
        end
        S_LNLO: begin
          lo_prod_q <= nl[31:0] * LN2_Q32;
          hi_q      <= nl[37:32];
          state_q   <= S_LNSUM;
        end
        S_LNSUM: begin
          dvd_q   <= ln_sum;
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        // Restoring divide, one quotient bit a cycle
        S_DIV: begin
          rem_q  <= ge ? SUM_W'(ren - {1'b0, total_q}) : ren[SUM_W-1:0];
          dvd_q  <= {dvd_q[36:0], ge};
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd37) begin
            state_q <= S_THR;
          end
        end
        S_THR: begin
          thr_lo_q <= up_q * total_q[31:0];
          state_q  <= S_THRSUM;
        end
        S_THRSUM: begin
          thr_q    <= thr_sum;
          addr_q   <= '0;
          issued_q <= 1'b0;
          pend_q   <= 1'b0;
          state_q  <= S_SCAN;
        end
        // Stream prefix sums and stop at the first one above the threshold
        S_SCAN: begin
          pend_q      <= rd_en_o;
          pend_last_q <= (addr_q == last_addr);
          if (rd_en_o) begin
            if (addr_q == last_addr) begin
              issued_q <= 1'b1;
            end else begin
              addr_q <= addr_q + ADDR_W'(1);
            end
          end
          if (finish) begin
            pend_q      <= 1'b0;
            out_valid_q <= 1'b1;
            status_q    <= ST_STEP;
            next_q      <= rd_tgt_i;
            time_q      <= (|dvd_q[37:32]) ? '1 : dvd_q[31:0];
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign next_state_o   = next_q;
  assign sojourn_time_o = time_q;

endmodule

>>> rtl/gillespie_jump_select.sv
// ----------------------------------------------------------------------------
// gillespie_jump_select
// One step of the Gillespie direct method. Option beats load one per cycle
// while the option memory is free and the job queue has room; the beat
// marked last (or a no_options beat) yields one result. A step result
// passes the job queue and pop, an exponent search on u+1, repeated
// squaring, the log product, the restoring divide, the pick threshold and
// a scan of the prefix sums up to the chosen option. The single option
// memory is held by the back end until its scan ends, so loading of the
// next state waits for that scan; absorbing and error results pass through
// the two-entry job queue without touching the memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gillespie_jump_select #(
  parameter int unsigned MAX_OPTIONS = gjs_pkg::MAX_OPTIONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] current_state_i,
  input  logic signed [31:0] target_state_i,
  input  logic [31:0]        rate_i,
  input  logic [31:0]        uniform_time_i,
  input  logic [31:0]        uniform_pick_i,
  input  logic               last_i,
  input  logic               no_options_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] next_state_o,
  output logic [31:0]        sojourn_time_o
);
  import gjs_pkg::*;

  `include "gillespie_jump_select_macros.svh"

  localparam int unsigned ADDR_W = $clog2(MAX_OPTIONS);
  localparam int unsigned CNT_W  = $clog2(MAX_OPTIONS + 1);
  localparam int unsigned SUM_W  = 32 + ADDR_W;
  localparam int unsigned JOB_W  = 2 + 32 + CNT_W + SUM_W + 64;

  logic              fj_valid;
  logic              fj_ready;
  logic [JOB_W-1:0]  fj_data;
  logic              bj_valid;
  logic              bj_ready;
  logic [JOB_W-1:0]  bj_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [SUM_W-1:0]  rd_sum;
  logic [31:0]       rd_tgt;
  logic              scan_done;
  logic              mem_busy;

  // Load and classify
  gjs_front #(
    .MAX_OPTIONS(MAX_OPTIONS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .current_state_i(current_state_i),
    .target_state_i (target_state_i),
    .rate_i         (rate_i),
    .uniform_time_i (uniform_time_i),
    .uniform_pick_i (uniform_pick_i),
    .last_i         (last_i),
    .no_options_i   (no_options_i),
    .job_valid_o    (fj_valid),
    .job_ready_i    (fj_ready),
    .job_data_o     (fj_data),
    .rd_en_i        (rd_en),
    .rd_addr_i      (rd_addr),
    .rd_sum_o       (rd_sum),
    .rd_tgt_o       (rd_tgt),
    .scan_done_i    (scan_done),
    .mem_busy_o     (mem_busy)
  );

  // Queue jobs
  gjs_job_fifo #(
    .DATA_W(JOB_W)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fj_valid),
    .in_ready_o (fj_ready),
    .in_data_i  (fj_data),
    .out_valid_o(bj_valid),
    .out_ready_i(bj_ready),
    .out_data_o (bj_data)
  );

  // Compute time and pick
  gjs_back #(
    .MAX_OPTIONS(MAX_OPTIONS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (bj_valid),
    .job_ready_o   (bj_ready),
    .job_data_i    (bj_data),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_sum_i      (rd_sum),
    .rd_tgt_i      (rd_tgt),
    .scan_done_o   (scan_done),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .next_state_o  (next_state_o),
    .sojourn_time_o(sojourn_time_o)
  );

  // Checks
  `GJS_ASSERT_NOW(a_err_fields, out_valid_o && (status_o == ST_ERROR), (next_state_o == '1) && (sojourn_time_o == '0), "error beat with bad fields")
  `GJS_ASSERT_NOW(a_abs_time, out_valid_o && (status_o == ST_ABSORB), sojourn_time_o == '0, "absorbed beat with nonzero time")
  `GJS_ASSERT_NOW(a_busy_stall, mem_busy, !in_ready_o, "beat taken while option memory is scanned")
  `GJS_ASSERT_NEXT(a_abs_nobusy, in_valid_i && in_ready_o && no_options_i, !mem_busy, "absorbing beat claimed the option memory")

endmodule
